FILE: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define IFE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Checked on every edge, reset included.
`define IFE_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

FILE: hdl/ife_pkg.sv
package ife_pkg;

	localparam logic [2:0] OP_PERCENT  = 3'd0;
	localparam logic [2:0] OP_CHAR     = 3'd1;
	localparam logic [2:0] OP_HEX      = 3'd2;
	localparam logic [2:0] OP_POINTER  = 3'd3;
	localparam logic [2:0] OP_UNSIGNED = 3'd4;
	localparam logic [2:0] OP_SIGNED   = 3'd5;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ALPHA   = 8'h37;

	localparam int unsigned MAX_DIGITS = 10;

	// ceil(2^35 / 10): (v * RECIP10) >> 35 == v / 10 for any 32-bit v
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	// One classified request, as handed from front to back.
	typedef struct packed {
		logic                         bad;      // flag conflict: one error result
		logic                         lit;      // single literal character
		logic [7:0]                   lit_char;
		logic                         ptr;      // "0x" prefix
		logic                         neg;      // '-' sign
		logic                         zf;       // '0' padding, sign first
		logic [5:0]                   pad_cnt;
		logic [3:0]                   ndig;
		logic [MAX_DIGITS-1:0][3:0]   digs;     // least significant at index 0
	} job_t;

endpackage

FILE: hdl/ife_channels.sv
interface ife_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] value;
	logic [5:0]  field_width;
	logic        zero_fill;

	modport source (output valid, operation, value, field_width, zero_fill, input ready);
	modport sink   (input valid, operation, value, field_width, zero_fill, output ready);
endinterface

interface ife_chr_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;
	logic       bad_format;

	modport source (output valid, out_char, last, bad_format, input ready);
	modport sink   (input valid, out_char, last, bad_format, output ready);
endinterface

FILE: hdl/ife_front.sv
module ife_front #(
	parameter int unsigned MAX_FIELD_WIDTH = 60
) (
	input  logic          clk,
	input  logic          arst_n,
	ife_req_if.sink       req,
	output ife_pkg::job_t job,
	output logic          job_push,
	input  logic          job_full
);
	import ife_pkg::*;

	localparam logic [5:0] MAX_W = 6'(MAX_FIELD_WIDTH);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_DIV  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t     state_q;
	job_t        job_q;
	logic [31:0] mag_q;
	logic [63:0] prod_q;
	logic [3:0]  idx_q;
	logic [5:0]  wid_q;

	// accept-cycle decode
	logic [5:0]  fw_sat;
	logic        bad;
	logic        dec;
	logic [3:0]  hex_n;
	// digit step
	logic [28:0] quo;
	logic [31:0] rem;
	// pad count
	logic [4:0]  used;

	assign req.ready = (state_q == F_IDLE);

	always_comb begin
		fw_sat = (req.field_width > MAX_W) ? MAX_W : req.field_width;
		bad = (req.operation > OP_SIGNED)
			|| ((req.operation == OP_PERCENT || req.operation == OP_CHAR)
				&& req.field_width != 6'd0)
			|| (req.operation == OP_POINTER && req.zero_fill);
		dec = !bad && (req.operation == OP_UNSIGNED || req.operation == OP_SIGNED);
		hex_n = 4'd1;
		for (int i = 1; i < 8; i++) begin
			if (req.value[4*i +: 4] != 4'd0)
				hex_n = 4'(i + 1);
		end
	end

	always_comb begin
		quo = prod_q[63:35];
		rem = mag_q - {quo, 3'b000} - {2'b00, quo, 1'b0};
	end

	always_comb begin
		used = 5'(job_q.ndig) + 5'(job_q.neg);
		job = job_q;
		job.pad_cnt = (!job_q.lit && wid_q > {1'b0, used}) ? wid_q - {1'b0, used} : 6'd0;
	end

	assign job_push = (state_q == F_PUSH) && !job_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE:  if (req.valid) state_q <= dec ? F_MUL : F_PUSH;
				F_MUL:   state_q <= F_DIV;
				F_DIV:   if (quo == 29'd0 || idx_q == 4'(MAX_DIGITS - 1)) state_q <= F_PUSH;
				F_PUSH:  if (!job_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: if (req.valid) begin
				job_q.bad      <= bad;
				job_q.lit      <= bad || req.operation == OP_PERCENT || req.operation == OP_CHAR;
				job_q.lit_char <= bad ? 8'h00 :
					(req.operation == OP_PERCENT) ? CH_PERCENT : req.value[7:0];
				job_q.ptr      <= !bad && req.operation == OP_POINTER;
				job_q.neg      <= !bad && req.operation == OP_SIGNED && req.value[31];
				job_q.zf       <= req.zero_fill;
				job_q.pad_cnt  <= 6'd0;
				job_q.ndig     <= (bad || req.operation == OP_PERCENT
					|| req.operation == OP_CHAR) ? 4'd0 : hex_n;
				for (int i = 0; i < 8; i++)
					job_q.digs[i] <= req.value[4*i +: 4];
				for (int i = 8; i < MAX_DIGITS; i++)
					job_q.digs[i] <= 4'd0;
				wid_q <= (req.operation == OP_POINTER) ?
					((fw_sat > 6'd2) ? fw_sat - 6'd2 : 6'd0) : fw_sat;
				mag_q <= (req.operation == OP_SIGNED && req.value[31]) ?
					(~req.value + 32'd1) : req.value;
				idx_q <= 4'd0;
			end
			F_MUL: begin
				prod_q <= 64'(mag_q) * 64'(RECIP10);
			end
			F_DIV: begin
				job_q.digs[idx_q] <= rem[3:0];
				mag_q  <= {3'b000, quo};
				prod_q <= 64'({3'b000, quo}) * 64'(RECIP10);
				idx_q  <= idx_q + 4'd1;
				job_q.ndig <= idx_q + 4'd1;
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/ife_queue.sv
module ife_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  ife_pkg::job_t wr_job,
	input  logic          push,
	output logic          full,
	output ife_pkg::job_t rd_job,
	output logic          avail,
	input  logic          pop
);
	import ife_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign avail  = (cnt_q != 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

FILE: hdl/ife_back.sv
module ife_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ife_pkg::job_t job,
	input  logic          job_avail,
	output logic          job_pop,
	ife_chr_if.source     chars
);
	import ife_pkg::*;

	logic                       busy_q;
	logic                       lit_q;
	logic                       bad_q;
	logic [7:0]                 lit_char_q;
	logic [1:0]                 pfx_q;
	logic                       sga_q;
	logic [5:0]                 pad_q;
	logic                       sgb_q;
	logic [3:0]                 dcnt_q;
	logic [7:0]                 pad_char_q;
	logic [MAX_DIGITS-1:0][3:0] digs_q;

	logic       ovalid_q;
	logic [7:0] ochar_q;
	logic       olast_q;
	logic       obad_q;

	logic       emit;
	logic       lit_n;
	logic [1:0] pfx_n;
	logic       sga_n;
	logic [5:0] pad_n;
	logic       sgb_n;
	logic [3:0] dcnt_n;
	logic [7:0] ch;
	logic [3:0] dg;
	logic [3:0] didx;
	logic       fin;

	assign job_pop = !busy_q && job_avail;
	assign emit    = busy_q && (!ovalid_q || chars.ready);

	assign chars.valid      = ovalid_q;
	assign chars.out_char   = ochar_q;
	assign chars.last       = olast_q;
	assign chars.bad_format = obad_q;

	// pick the next piece: literal, prefix, leading sign, pad, trailing sign, digits
	always_comb begin
		lit_n  = lit_q;
		pfx_n  = pfx_q;
		sga_n  = sga_q;
		pad_n  = pad_q;
		sgb_n  = sgb_q;
		dcnt_n = dcnt_q;
		didx   = dcnt_q - 4'd1;
		dg     = digs_q[didx];
		if (lit_q) begin
			ch = lit_char_q;
			lit_n = 1'b0;
		end else if (pfx_q != 2'd0) begin
			ch = (pfx_q == 2'd2) ? CH_ZERO : CH_X;
			pfx_n = pfx_q - 2'd1;
		end else if (sga_q) begin
			ch = CH_MINUS;
			sga_n = 1'b0;
		end else if (pad_q != 6'd0) begin
			ch = pad_char_q;
			pad_n = pad_q - 6'd1;
		end else if (sgb_q) begin
			ch = CH_MINUS;
			sgb_n = 1'b0;
		end else begin
			ch = (dg <= 4'd9) ? CH_ZERO + 8'(dg) : CH_ALPHA + 8'(dg);
			dcnt_n = dcnt_q - 4'd1;
		end
		fin = !lit_n && pfx_n == 2'd0 && !sga_n && pad_n == 6'd0 && !sgb_n && dcnt_n == 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (job_pop)
				busy_q <= 1'b1;
			else if (emit && fin)
				busy_q <= 1'b0;
			if (emit)
				ovalid_q <= 1'b1;
			else if (chars.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			lit_q      <= job.lit;
			bad_q      <= job.bad;
			lit_char_q <= job.lit_char;
			pfx_q      <= job.ptr ? 2'd2 : 2'd0;
			sga_q      <= job.neg && job.zf;
			sgb_q      <= job.neg && !job.zf;
			pad_q      <= job.pad_cnt;
			dcnt_q     <= job.ndig;
			pad_char_q <= job.zf ? CH_ZERO : CH_SPACE;
			digs_q     <= job.digs;
		end else if (emit) begin
			lit_q  <= lit_n;
			pfx_q  <= pfx_n;
			sga_q  <= sga_n;
			pad_q  <= pad_n;
			sgb_q  <= sgb_n;
			dcnt_q <= dcnt_n;
		end
		if (emit) begin
			ochar_q <= ch;
			olast_q <= fin;
			obad_q  <= bad_q;
		end
	end

endmodule

FILE: hdl/integer_format_emitter.sv
// Integer format emitter: turns one conversion request into ASCII characters.
// Request channel (req): operation, value, field_width, zero_fill. Operations
// are percent, char, uppercase hex, pointer ("0x" + hex), unsigned and signed
// decimal. Character channel (chars): one out_char per item, last on the final
// character of a request; a flag conflict yields a single item with
// bad_format and last set and out_char zero.
// The front classifies a request and builds its digits; a two-entry job queue
// hands it to the back, which emits one character per cycle into an output
// register while chars is not stalled.
// Percent, char, hex, pointer and errors go straight from the front's idle
// state to its push state; decimal passes through a multiply state and then a
// divide loop, one reciprocal multiply per digit. The back loads a job, then
// emits its characters (up to 60); it takes a new job only once done.
// Sustained rate is set by the slower side: the digit loop or the character
// count of each request.
// Reset clears the front state, the queue and the output valid; no request is
// in flight afterward. A stall on chars holds the current character; the
// back stops, the queue fills, and then req.ready drops.
module integer_format_emitter #(
	parameter int unsigned MAX_FIELD_WIDTH = 60
) (
	input  logic      clk,
	input  logic      arst_n,
	ife_req_if.sink   req,
	ife_chr_if.source chars
);
	import ife_pkg::*;

	job_t front_job;   // job as built by the front
	job_t queue_job;   // head of the queue
	logic push;
	logic full;
	logic avail;
	logic pop;

	ife_front #(
		.MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.job      (front_job),
		.job_push (push),
		.job_full (full)
	);

	ife_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_job (front_job),
		.push   (push),
		.full   (full),
		.rd_job (queue_job),
		.avail  (avail),
		.pop    (pop)
	);

	ife_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_avail (avail),
		.job_pop   (pop),
		.chars     (chars)
	);

endmodule

FILE: hdl/ife_checker.sv
`include "assert_macros.svh"

module ife_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       last,
	input logic       bad_format
);

	// a stalled character stays put
	`IFE_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last) && $stable(bad_format))

	// an error item is the whole answer to its request
	`IFE_ASSERT(a_bad_is_last, clk, arst_n, out_valid && bad_format |-> last)

	// an error item carries no character
	`IFE_ASSERT(a_bad_no_char, clk, arst_n, out_valid && bad_format |-> out_char == 8'h00)

	// nothing is offered on the first edge after reset
	`IFE_ASSERT_ALWAYS(a_reset_quiet, clk, $rose(arst_n) |-> !out_valid)

endmodule

bind integer_format_emitter ife_checker u_ife_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (chars.valid),
	.out_ready  (chars.ready),
	.out_char   (chars.out_char),
	.last       (chars.last),
	.bad_format (chars.bad_format)
);

FILE: tb/sv/tb_integer_format_emitter.sv
`timescale 1ns / 100ps

// Self-checking bench for integer_format_emitter. Requests go in on the req
// channel; every character item that comes out on the chars channel is
// matched, in order, against a queue that a behavioral formatter fills when a
// request is accepted.
module tb_integer_format_emitter;
	import ife_pkg::*;

	localparam int FIELD_LIMIT = 60;
	localparam int IDLE_PCT    = 11;     // chance of an idle cycle per side
	localparam int HOLDOFF     = 400;    // long receiver stall, in cycles
	localparam int QUIET_LIMIT = 3000;   // watchdog: cycles with no handshake
	localparam int SETTLE      = 30;     // tail after the last character
	localparam int MAX_REPORTS = 10;

	// Operation codes the block does not define; both must be rejected.
	localparam logic [2:0] OP_UNDEF_LO = 3'd6;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;
	// out_char carried by an error item
	localparam logic [7:0] CH_NONE = 8'h00;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic       bad_format;
	} char_item_t;

	logic clk;
	logic arst_n;

	ife_req_if req_bus ();
	ife_chr_if chr_bus ();

	integer_format_emitter #(
		.MAX_FIELD_WIDTH(FIELD_LIMIT)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.chars (chr_bus)
	);

	char_item_t expected_chars[$];
	int         mismatches   = 0;
	bit         no_idle      = 0;   // both sides run without gaps while set
	bit         holdoff_req  = 0;   // asks the receiver for one long stall
	int         holdoff_left = 0;
	int         quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Behavioral formatter: appends the characters one request produces.
	// ------------------------------------------------------------------
	function automatic void predict_chars(input logic [2:0] op, input logic [31:0] value,
			input logic [5:0] width_in, input logic zf);
		int         w;
		int         used;
		int         n;
		logic [7:0] pad;
		logic       neg;
		logic [31:0] v;
		logic [7:0] digits[$];
		logic [7:0] text[$];
		char_item_t item;

		w = (width_in > FIELD_LIMIT) ? FIELD_LIMIT : int'(width_in);

		// Flag conflicts and undefined codes: a single error item, no text.
		// Note the width test uses the raw field, before saturation.
		if (op == OP_UNDEF_LO || op == OP_UNDEF_HI ||
				((op == OP_PERCENT || op == OP_CHAR) && width_in != 0) ||
				(op == OP_POINTER && zf)) begin
			item.out_char   = CH_NONE;
			item.last       = 1'b1;
			item.bad_format = 1'b1;
			expected_chars.push_back(item);
			return;
		end

		pad = zf ? CH_ZERO : CH_SPACE;
		neg = (op == OP_SIGNED) && value[31];

		// Digit string, most significant first, no leading zeros.
		if (op == OP_HEX || op == OP_POINTER) begin
			v = value;
			n = 8;
			while (n > 1 && v[31:28] == 4'h0) begin
				v = v << 4;
				n--;
			end
			repeat (n) begin
				digits.push_back((v[31:28] <= 4'd9) ? CH_ZERO + 8'(v[31:28])
						: CH_ALPHA + 8'(v[31:28]));
				v = v << 4;
			end
		end else if (op == OP_UNSIGNED || op == OP_SIGNED) begin
			v = neg ? (~value + 32'd1) : value;
			do begin
				digits.push_front(CH_ZERO + 8'(v % 32'd10));
				v = v / 32'd10;
			end while (v != 0);
		end
		n = digits.size();

		case (op)
			OP_PERCENT: text.push_back(CH_PERCENT);
			OP_CHAR: text.push_back(value[7:0]);
			OP_POINTER: begin
				// prefix counts toward the width; padding is always spaces here
				text.push_back(CH_ZERO);
				text.push_back(CH_X);
				w = (w > 2) ? w - 2 : 0;
				for (int i = n; i < w; i++) text.push_back(pad);
				foreach (digits[i]) text.push_back(digits[i]);
			end
			OP_SIGNED: begin
				// sign goes ahead of zeros but after spaces
				used = n + (neg ? 1 : 0);
				if (neg && zf) text.push_back(CH_MINUS);
				for (int i = used; i < w; i++) text.push_back(pad);
				if (neg && !zf) text.push_back(CH_MINUS);
				foreach (digits[i]) text.push_back(digits[i]);
			end
			default: begin
				// hex and unsigned: padding then digits
				for (int i = n; i < w; i++) text.push_back(pad);
				foreach (digits[i]) text.push_back(digits[i]);
			end
		endcase

		foreach (text[i]) begin
			item.out_char   = text[i];
			item.last       = (i == text.size() - 1);
			item.bad_format = 1'b0;
			expected_chars.push_back(item);
		end
	endfunction

	// ------------------------------------------------------------------
	// Request side: fields change on the falling edge, the handshake is
	// sampled on the rising edge. valid gets one assignment per edge.
	// ------------------------------------------------------------------
	task automatic send_request(input logic [2:0] op, input logic [31:0] value,
			input logic [5:0] width_in, input logic zf);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid       <= 1'b1;
		req_bus.operation   <= op;
		req_bus.value       <= value;
		req_bus.field_width <= width_in;
		req_bus.zero_fill   <= zf;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		predict_chars(op, value, width_in, zf);
	endtask

	// Stop offering and wait for every outstanding character.
	task automatic wait_drained();
		@(negedge clk);
		req_bus.valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	// Random request biased toward legal conversions with tricky values.
	task automatic send_random(input int count);
		logic [2:0]  op;
		logic [31:0] value;
		logic [31:0] p10;
		logic [5:0]  width_in;
		logic        zf;
		int          r;

		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 8) op = OP_PERCENT;
			else if (r < 16) op = OP_CHAR;
			else if (r < 36) op = OP_HEX;
			else if (r < 52) op = OP_POINTER;
			else if (r < 72) op = OP_UNSIGNED;
			else if (r < 94) op = OP_SIGNED;
			else op = $urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO;

			case ($urandom_range(0, 5))
				0: value = $urandom();
				1: value = $urandom_range(0, 15);
				2: begin
					// around a power of ten, where the digit count changes
					p10 = 32'd1;
					repeat ($urandom_range(0, 9)) p10 = p10 * 32'd10;
					value = p10 + $urandom_range(0, 2) - 32'd1;
				end
				3: value = 32'hFFFF_FFFF - $urandom_range(0, 15);
				4: value = 32'h8000_0000 + $urandom_range(0, 15);
				default: value = 32'd1 << $urandom_range(0, 31);
			endcase

			if ($urandom_range(0, 99) < 80) width_in = 6'($urandom_range(0, 12));
			else width_in = 6'($urandom_range(13, 63));
			zf = 1'($urandom_range(0, 1));

			// percent and char mostly well formed; pointer rarely zero-filled
			if ((op == OP_PERCENT || op == OP_CHAR) && $urandom_range(0, 99) < 85)
				width_in = '0;
			if (op == OP_POINTER)
				zf = ($urandom_range(0, 99) < 10);

			send_request(op, value, width_in, zf);
		end
	endtask

	// ------------------------------------------------------------------
	// Test phases
	// ------------------------------------------------------------------
	task automatic test_directed();
		send_request(OP_PERCENT,  32'h0,          6'd0,  1'b0);
		send_request(OP_PERCENT,  32'hFFFF_FFFF,  6'd0,  1'b1); // zero fill ignored
		send_request(OP_CHAR,     32'h0000_0000,  6'd0,  1'b0);
		send_request(OP_CHAR,     32'hFFFF_FFFF,  6'd0,  1'b1);
		send_request(OP_HEX,      32'h0,          6'd0,  1'b0); // zero prints one digit
		send_request(OP_HEX,      32'hFFFF_FFFF,  6'd0,  1'b0);
		send_request(OP_HEX,      32'h0009_00AF,  6'd60, 1'b1);
		send_request(OP_HEX,      32'h1,          6'd61, 1'b1); // width saturates
		send_request(OP_POINTER,  32'h0,          6'd0,  1'b0);
		send_request(OP_POINTER,  32'hDEAD_BEEF,  6'd63, 1'b0);
		send_request(OP_POINTER,  32'h1234,       6'd1,  1'b0);
		send_request(OP_UNSIGNED, 32'h0,          6'd0,  1'b1);
		send_request(OP_UNSIGNED, 32'hFFFF_FFFF,  6'd12, 1'b1);
		send_request(OP_UNSIGNED, 32'd1000000000, 6'd1,  1'b0);
		send_request(OP_SIGNED,   32'h8000_0000,  6'd0,  1'b0); // most negative
		send_request(OP_SIGNED,   -32'sd5,        6'd8,  1'b1); // '-' then zeros
		send_request(OP_SIGNED,   -32'sd5,        6'd8,  1'b0); // spaces then '-'
		send_request(OP_SIGNED,   32'h7FFF_FFFF,  6'd11, 1'b1);
		send_request(OP_SIGNED,   32'd123,        6'd63, 1'b0);
		// flag conflicts and undefined codes
		send_request(OP_PERCENT,  32'h0,          6'd1,  1'b0);
		send_request(OP_CHAR,     32'h41,         6'd63, 1'b0);
		send_request(OP_POINTER,  32'h10,         6'd0,  1'b1);
		send_request(OP_UNDEF_LO, 32'h5,          6'd4,  1'b0);
		send_request(OP_UNDEF_HI, 32'hFFFF_FFFF,  6'd63, 1'b1);
		wait_drained();
	endtask

	// Gap-free stretch on both sides.
	task automatic test_steady_burst();
		no_idle = 1'b1;
		send_random(80);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// Receiver stalls for a long time while requests keep coming, so the
	// output register and the job queue fill and req.ready must drop.
	task automatic test_output_holdoff();
		holdoff_req = 1'b1;
		send_random(30);
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Character side
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (holdoff_left != 0) begin
			chr_bus.ready <= 1'b0;
			holdoff_left--;
		end else if (holdoff_req) begin
			holdoff_req = 1'b0;
			holdoff_left = HOLDOFF - 1;
			chr_bus.ready <= 1'b0;
		end else begin
			chr_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic note_mismatch(input string what, input char_item_t want,
			input char_item_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s: char %h/%h last %b/%b bad_format %b/%b (expected/actual)",
					$realtime, what, want.out_char, got.out_char, want.last, got.last,
					want.bad_format, got.bad_format);
	endtask

	// Each accepted character is compared with the oldest expectation.
	always @(posedge clk) begin
		char_item_t got;
		char_item_t want;
		if (arst_n && chr_bus.valid && chr_bus.ready) begin
			got.out_char   = chr_bus.out_char;
			got.last       = chr_bus.last;
			got.bad_format = chr_bus.bad_format;
			if (expected_chars.size() == 0) begin
				want = '0;
				note_mismatch("unexpected item", want, got);
			end else begin
				want = expected_chars.pop_front();
				if (got !== want)
					note_mismatch("mismatch", want, got);
			end
		end
	end

	// Watchdog: a run with no handshake for too long is hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (chr_bus.valid && chr_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("integer_format_emitter regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		req_bus.valid       = 1'b0;
		req_bus.operation   = OP_PERCENT;
		req_bus.value       = '0;
		req_bus.field_width = '0;
		req_bus.zero_fill   = 1'b0;
		chr_bus.ready       = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		send_random(200);
		wait_drained();     // sender pauses until every character is back
		test_steady_burst();
		test_output_holdoff();
		send_random(136);
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && expected_chars.size() == 0)
			$display("integer_format_emitter regression: pass");
		else
			$display("integer_format_emitter regression: fail");
		$finish;
	end

endmodule
